[hdl/wildcard_name_matcher_defines.svh]
// Assertion macros used by the matcher's top-level RTL file.
// WNM_ASSERT checks outside reset only; WNM_ASSERT_RST also checks while reset is held.
`ifndef WILDCARD_NAME_MATCHER_DEFINES_SVH
`define WILDCARD_NAME_MATCHER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WNM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define WNM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define WNM_ASSERT(label, prop, msg)
`define WNM_ASSERT_RST(label, prop, msg)
`endif

`endif

[hdl/wnm_pkg.sv]
package wnm_pkg;

    localparam int PATTERN_MAX_CHARS = 32;
    localparam int NPOS              = PATTERN_MAX_CHARS + 1;
    localparam int LEN_W             = $clog2(NPOS);
    localparam int CFG_DATA_W        = 64;
    localparam int CHARS_PER_WORD    = CFG_DATA_W / 8;
    localparam int CFG_IDX_W         = 3;
    localparam int LEVELS            = $clog2(NPOS);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd4;

    localparam logic [7:0] CH_ONE = 8'h3F;
    localparam logic [7:0] CH_ANY = 8'h2A;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UZ  = 8'h5A;
    localparam logic [7:0] CH_LA  = 8'h61;

    typedef logic [NPOS-1:0] t_pos_set;

    typedef struct packed {
        logic [PATTERN_MAX_CHARS-1:0][7:0] chars;
        logic [LEN_W-1:0]                  len;
    } t_pat_cfg;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[CH_UA:CH_UZ]}) begin
            r = c + (CH_LA - CH_UA);
        end
        return r;
    endfunction

endpackage

[hdl/wnm_cfg_regs.sv]
module wnm_cfg_regs (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [wnm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [wnm_pkg::CFG_DATA_W-1:0]         i_cfg_wdata,
    output wnm_pkg::t_pat_cfg                      o_cfg
);
    import wnm_pkg::*;

    logic [PATTERN_MAX_CHARS-1:0][7:0] r_chars;
    logic [LEN_W-1:0]                  r_len;
    logic [LEN_W-1:0]                  w_len_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars <= '0;
            r_len   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CHARS_A: r_chars[1*CHARS_PER_WORD-1:0*CHARS_PER_WORD] <= i_cfg_wdata;
                REG_CHARS_B: r_chars[2*CHARS_PER_WORD-1:1*CHARS_PER_WORD] <= i_cfg_wdata;
                REG_CHARS_C: r_chars[3*CHARS_PER_WORD-1:2*CHARS_PER_WORD] <= i_cfg_wdata;
                REG_CHARS_D: r_chars[4*CHARS_PER_WORD-1:3*CHARS_PER_WORD] <= i_cfg_wdata;
                REG_LENGTH:  r_len <= i_cfg_wdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A length above the pattern capacity saturates.
    assign w_len_used = (r_len > LEN_W'(PATTERN_MAX_CHARS)) ? LEN_W'(PATTERN_MAX_CHARS) : r_len;

    assign o_cfg.chars = r_chars;
    assign o_cfg.len   = w_len_used;

endmodule

[hdl/wnm_step.sv]
module wnm_step (
    input  wnm_pkg::t_pat_cfg  i_cfg,
    input  wnm_pkg::t_pos_set  i_active,
    input  logic [7:0]         i_name_char,
    output wnm_pkg::t_pos_set  o_next,
    output logic               o_match
);
    import wnm_pkg::*;

    t_pos_set w_cur;
    logic [7:0] w_fc;

    assign w_fc = fold_case(i_name_char);

    // Star closure as a parallel prefix: generate is a live position, propagate
    // is a '*' just before the position.
    always_comb begin
        t_pos_set g;
        t_pos_set p;
        t_pos_set gn;
        t_pos_set pn;
        for (int j = 0; j < NPOS; j++) begin
            g[j] = i_active[j] && (LEN_W'(j) <= i_cfg.len);
            if (j == 0) begin
                p[j] = 1'b0;
            end else begin
                p[j] = (LEN_W'(j - 1) < i_cfg.len) && (i_cfg.chars[j-1] == CH_ANY);
            end
        end
        for (int k = 0; k < LEVELS; k++) begin
            for (int j = 0; j < NPOS; j++) begin
                if (j >= (1 << k)) begin
                    gn[j] = g[j] | (p[j] & g[j - (1 << k)]);
                    pn[j] = p[j] & p[j - (1 << k)];
                end else begin
                    gn[j] = g[j];
                    pn[j] = 1'b0;
                end
            end
            g = gn;
            p = pn;
        end
        w_cur = g;
    end

    always_comb begin
        o_next = '0;
        for (int i = 0; i < PATTERN_MAX_CHARS; i++) begin
            if (w_cur[i] && (LEN_W'(i) < i_cfg.len)) begin
                if (i_cfg.chars[i] == CH_ANY) begin
                    o_next[i] = 1'b1;
                end else if ((i_cfg.chars[i] == CH_ONE) ||
                             (fold_case(i_cfg.chars[i]) == w_fc)) begin
                    o_next[i+1] = 1'b1;
                end
            end
        end
    end

    assign o_match = w_cur[i_cfg.len];

endmodule

[hdl/wildcard_name_matcher.sv]
// Wildcard name matcher.
// The name arrives on the input channel one character per request; a request
// with i_end_of_name high closes the name and carries no character. The
// pattern ('?' one character, '*' any run) must be loaded through the write
// port while idle; the block does not enforce it. Letters compare caselessly.
// Only a terminator request produces a result: o_name_matches on the output
// channel; the terminator is first loaded into the input register, and the
// result is registered in the result register when the terminator leaves it.
// Character requests produce nothing.
// Throughput is one request per cycle unless a terminator is held by a stall;
// each character updates all 33 pattern positions in a single logic stage.
// When the receiver stalls, a finished result waits in the result register
// while character requests keep flowing; a following terminator holds in the
// input register until the result is taken, and input ready drops then.
// Reset clears the pattern, sets the length to zero, empties both registers
// and leaves only pattern position zero live.
`include "wildcard_name_matcher_defines.svh"

module wildcard_name_matcher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_name_char,
    input  logic                                i_end_of_name,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_name_matches,
    input  logic                                i_cfg_we,
    input  logic [wnm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wnm_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import wnm_pkg::*;

    t_pat_cfg   w_cfg;
    t_pos_set   w_next;
    logic       w_match;
    logic       w_adv;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eon;
    t_pos_set   r_active;
    t_pos_set   n_active;
    logic       r_out_valid;
    logic       r_out_match;

    wnm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    wnm_step u_step (
        .i_cfg       (w_cfg),
        .i_active    (r_active),
        .i_name_char (r_in_char),
        .o_next      (w_next),
        .o_match     (w_match)
    );

    // A character always retires; a terminator needs room in the result register.
    assign w_adv      = r_in_valid && (!r_in_eon || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_comb begin
        n_active = r_active;
        if (w_adv) begin
            n_active = r_in_eon ? NPOS'(1) : w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_active    <= NPOS'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_active <= n_active;
            if (w_adv && r_in_eon) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_char <= i_name_char;
            r_in_eon  <= i_end_of_name;
        end
        if (w_adv && r_in_eon) begin
            r_out_match <= w_match;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_name_matches = r_out_match;

    `WNM_ASSERT(a_out_from_term, $rose(r_out_valid) |-> $past(w_adv && r_in_eon), "result without a terminator")
    `WNM_ASSERT(a_term_restarts, (w_adv && r_in_eon) |=> (r_active == NPOS'(1)), "active set not restarted")
    `WNM_ASSERT(a_term_waits, (r_in_valid && r_in_eon && r_out_valid && !i_out_ready) |-> !o_in_ready, "terminator overran a held result")
    `WNM_ASSERT_RST(a_reset_state, !i_rst_n |=> (!r_in_valid && !r_out_valid && (r_active == NPOS'(1))), "bad state after reset")

endmodule
